/* design/upa_pkg.sv */
`default_nettype none
package upa_pkg;

	// Widest column index that the MAX_COLUMNS range can ask for.
	localparam int COL_W = 12;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_COEFFICIENT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_V_COEFFICIENT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_VELOCITY_START = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_VELOCITY_STEP  = 3'd5;

	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_ZERO = 2'd1,
		KIND_CALC = 2'd2
	} kind_t;

	typedef struct packed {
		logic [12:0]        row_count;
		logic [8:0]         column_count;
		logic [31:0]        x_coef;
		logic [31:0]        v_coef;
		logic signed [31:0] vel_start;
		logic signed [31:0] vel_step;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] force_val;
		logic [COL_W-1:0]   col;
		kind_t              kind;
		logic               emit;
		logic               last;
	} item_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh7FFFFFFF) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -66'sh80000000) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/upa_front.sv */
`default_nettype none
module upa_front #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS = 4096
) (
	input  wire                clk,
	input  wire                arst_n,
	input  upa_pkg::cfg_t      cfg,
	input  wire                push,
	input  wire signed [31:0]  sample,
	input  wire signed [31:0]  row_force,
	output upa_pkg::item_t     item
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);

	logic [RW-1:0]       row_q;
	logic [CW-1:0]       col_q;
	logic                primed_q;
	logic signed [31:0]  older_f_q;
	logic signed [31:0]  newer_f_q;
	logic [RW:0]         nx;
	logic [RW:0]         held;
	logic [RW:0]         r_ext;
	logic [CW:0]         nv;
	logic [CW:0]         j_ext;

	always_comb begin
		if (cfg.row_count < 13'd3) begin
			nx = (RW+1)'(3);
		end else if (32'(cfg.row_count) > 32'(MAX_ROWS)) begin
			nx = (RW+1)'(MAX_ROWS);
		end else begin
			nx = (RW+1)'(cfg.row_count);
		end
		if (cfg.column_count < 9'd3) begin
			nv = (CW+1)'(3);
		end else if (32'(cfg.column_count) > 32'(MAX_COLUMNS)) begin
			nv = (CW+1)'(MAX_COLUMNS);
		end else begin
			nv = (CW+1)'(cfg.column_count);
		end
	end

	assign r_ext = {1'b0, row_q};
	assign j_ext = {1'b0, col_q};
	// The row that comes out is one behind the row that streams in.
	assign held = (row_q != '0) ? r_ext - (RW+1)'(1) : nx - (RW+1)'(1);

	always_comb begin
		item.x = sample;
		item.force_val = (col_q == '0) ? newer_f_q : older_f_q;
		item.col = upa_pkg::COL_W'(col_q);
		item.emit = (row_q != '0) || primed_q;
		item.last = (row_q == '0) && (j_ext == nv - (CW+1)'(1));
		if (held == '0 || held >= nx - (RW+1)'(1)) begin
			item.kind = upa_pkg::KIND_PASS;
		end else if (col_q == '0 || j_ext >= nv - (CW+1)'(1)) begin
			item.kind = upa_pkg::KIND_ZERO;
		end else begin
			item.kind = upa_pkg::KIND_CALC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			primed_q <= 1'b0;
			older_f_q <= '0;
			newer_f_q <= '0;
		end else if (push) begin
			if (col_q == '0) begin
				older_f_q <= newer_f_q;
				newer_f_q <= row_force;
			end
			if (j_ext + (CW+1)'(1) >= nv) begin
				col_q <= '0;
				if (r_ext + (RW+1)'(1) >= nx) begin
					row_q <= '0;
					primed_q <= 1'b1;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* design/upa_queue.sv */
`default_nettype none
module upa_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  upa_pkg::item_t  push_item,
	output logic            full,
	input  wire             pop,
	output logic            not_empty,
	output upa_pkg::item_t  head
);

	upa_pkg::item_t ent_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/upa_back.sv */
`default_nettype none
module upa_back #(
	parameter int MAX_COLUMNS = 256
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  upa_pkg::cfg_t       cfg,
	input  wire                 q_valid,
	input  upa_pkg::item_t      q_item,
	output logic                pop,
	output logic                result_valid,
	input  wire                 result_ready,
	output logic signed [31:0]  stage_value,
	output logic                is_last
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int PW = CW + 33;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_DIFF = 7'b0000100,
		S_MUL1 = 7'b0001000,
		S_COUR = 7'b0010000,
		S_MUL2 = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	upa_pkg::item_t itm_q;

	// Each entry holds {newer row, older row} for one column.
	logic [63:0] mem [MAX_COLUMNS];
	logic [63:0] rd_j_q;
	logic [63:0] rd_n_q;
	logic [CW-1:0] j;
	logic [CW-1:0] jn;

	logic signed [31:0]   left_q;
	logic signed [31:0]   cur_q;
	logic signed [PW-1:0] prod_q;
	logic signed [31:0]   vel_q;
	logic signed [32:0]   dxb_q, dxf_q, dv_q, dx_q;
	logic signed [64:0]   px_q, pf_q, tx_q, tf_q;
	logic signed [31:0]   cx_q, cf_q;
	logic signed [31:0]   cur;
	logic signed [31:0]   old;
	logic signed [31:0]   right;
	logic signed [31:0]   calc;
	logic signed [31:0]   res;
	logic                 can_load;

	assign j = itm_q.col[CW-1:0];
	assign jn = (j == CW'(MAX_COLUMNS - 1)) ? '0 : j + CW'(1);
	assign cur = rd_j_q[63:32];
	assign old = rd_j_q[31:0];
	assign right = rd_n_q[63:32];
	assign pop = (state_q == S_IDLE) && q_valid;
	assign can_load = !result_valid || result_ready;

	assign calc = upa_pkg::sat32(66'(cur_q) - 66'(tx_q >>> 16) - 66'(tf_q >>> 16));

	always_comb begin
		case (itm_q.kind)
			upa_pkg::KIND_PASS: res = cur_q;
			upa_pkg::KIND_ZERO: res = '0;
			upa_pkg::KIND_CALC: res = calc;
			default:            res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					itm_q <= q_item;
				end
			end
			S_READ: begin
				rd_j_q <= mem[j];
				rd_n_q <= mem[jn];
				prod_q <= $signed({1'b0, j}) * cfg.vel_step;
			end
			S_DIFF: begin
				mem[j] <= {itm_q.x, cur};
				left_q <= cur;
				cur_q <= cur;
				vel_q <= upa_pkg::sat32(66'(cfg.vel_start) + 66'(prod_q));
				dxb_q <= 33'(cur) - 33'(old);
				dxf_q <= 33'(itm_q.x) - 33'(cur);
				dv_q <= (itm_q.force_val >= 0) ? 33'(cur) - 33'(left_q)
				                               : 33'(right) - 33'(cur);
			end
			S_MUL1: begin
				px_q <= vel_q * $signed({1'b0, cfg.x_coef});
				pf_q <= itm_q.force_val * $signed({1'b0, cfg.v_coef});
			end
			S_COUR: begin
				cx_q <= upa_pkg::sat32(66'(px_q >>> 24));
				cf_q <= upa_pkg::sat32(66'(pf_q >>> 24));
				dx_q <= (vel_q >= 0) ? dxb_q : dxf_q;
			end
			S_MUL2: begin
				tx_q <= cx_q * dx_q;
				tf_q <= cf_q * dv_q;
			end
			S_FIN: begin
				if (itm_q.emit && can_load) begin
					stage_value <= res;
					is_last <= itm_q.last;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (q_valid) state_q <= S_READ;
				S_READ: state_q <= S_DIFF;
				S_DIFF: state_q <= S_MUL1;
				S_MUL1: state_q <= S_COUR;
				S_COUR: state_q <= S_MUL2;
				S_MUL2: state_q <= S_FIN;
				S_FIN: begin
					if (!itm_q.emit) begin
						state_q <= S_IDLE;
					end else if (can_load) begin
						result_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/upwind_phase_space_advection_top.sv */
`default_nettype none
// Channel   Handshake                    Payload
// input     sample_valid/sample_ready    sample, row_force
// result    result_valid/result_ready    stage_value, is_last
// config    write_enable                 write_index, write_data
//
// Each sample beat passes through the arithmetic sequencer, which runs one cell at a time
// through buffer read, differencing, a multiply, Courant scaling, a second multiply and output.
// A two-entry queue lets input beats be taken while the sequencer is busy.
// Reset clears indices, forces and control; row buffers are undefined until written.
// A stalled result holds the sequencer in its last step; the input stalls when the queue is full.
module upwind_phase_space_advection_top #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS = 4096
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                sample_valid,
	output logic               sample_ready,
	input  wire signed [31:0]  sample,
	input  wire signed [31:0]  row_force,
	output logic               result_valid,
	input  wire                result_ready,
	output logic signed [31:0] stage_value,
	output logic               is_last,
	input  wire                write_enable,
	input  wire [2:0]          write_index,
	input  wire [31:0]         write_data
);

	upa_pkg::cfg_t  cfg_q;
	upa_pkg::item_t f_item;
	upa_pkg::item_t q_head;
	logic           push;
	logic           full;
	logic           q_valid;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count <= 13'd64;
			cfg_q.column_count <= 9'd64;
			cfg_q.x_coef <= '0;
			cfg_q.v_coef <= '0;
			cfg_q.vel_start <= '0;
			cfg_q.vel_step <= '0;
		end else if (write_enable) begin
			case (write_index)
				upa_pkg::REG_ROW_COUNT:      cfg_q.row_count <= write_data[12:0];
				upa_pkg::REG_COLUMN_COUNT:   cfg_q.column_count <= write_data[8:0];
				upa_pkg::REG_X_COEFFICIENT:  cfg_q.x_coef <= write_data;
				upa_pkg::REG_V_COEFFICIENT:  cfg_q.v_coef <= write_data;
				upa_pkg::REG_VELOCITY_START: cfg_q.vel_start <= write_data;
				upa_pkg::REG_VELOCITY_STEP:  cfg_q.vel_step <= write_data;
				default: begin
				end
			endcase
		end
	end

	assign sample_ready = !full;
	assign push = sample_valid && sample_ready;

	upa_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.sample(sample),
		.row_force(row_force),
		.item(f_item)
	);

	upa_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(f_item),
		.full(full),
		.pop(pop),
		.not_empty(q_valid),
		.head(q_head)
	);

	upa_back #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_head),
		.pop(pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.stage_value(stage_value),
		.is_last(is_last)
	);

endmodule
`default_nettype wire
